@@ sv/gvd_pkg.sv @@
`default_nettype none
package gvd_pkg;

    localparam int DivBits = 32;
    localparam int DenBits = 16;
    localparam int EntryBytesLog = 5;
    localparam logic [31:0] Fat12Limit = 32'd4085;
    localparam logic [31:0] Fat16Limit = 32'd65525;

    typedef enum logic [1:0] {
        KIND_FAT12   = 2'd0,
        KIND_FAT16   = 2'd1,
        KIND_FAT32   = 2'd2,
        KIND_UNKNOWN = 2'd3
    } fs_kind_t;

    typedef struct packed {
        logic [15:0] bytes_per_sector;
        logic [7:0]  sectors_per_cluster;
        logic [15:0] reserved_sectors;
        logic [7:0]  table_copies;
        logic [15:0] sectors_per_table;
        logic [15:0] root_entry_count;
        logic [15:0] total_sectors_short;
        logic [31:0] total_sectors_long;
    } geo_req_t;

    typedef struct packed {
        logic [1:0]  fs_kind;
        logic [21:0] root_dir_sectors;
        logic [31:0] data_sector_count;
        logic [31:0] cluster_total;
        logic [23:0] root_start_sector;
        logic [24:0] data_start_sector;
        logic [23:0] cluster_bytes;
        logic        geometry_error;
    } geo_rsp_t;

    typedef struct packed {
        logic [DivBits-1:0] num;
        logic [DenBits-1:0] den;
        logic [DenBits:0]   rem;
        logic [DivBits-1:0] quo;
    } div_t;

    typedef struct packed {
        logic        unknown;
        logic [7:0]  spc;
        logic [23:0] root_start;
        logic [23:0] cbytes;
        logic [31:0] total;
        logic [21:0] rds;
        logic [24:0] data_start;
        logic [31:0] data;
        logic        err;
    } ctx_t;

endpackage
`default_nettype wire

@@ sv/gvd_div_cell.sv @@
`default_nettype none
module gvd_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          prev_valid,
    input  wire gvd_pkg::div_t prev_div,
    input  wire gvd_pkg::ctx_t prev_ctx,
    output logic               valid,
    output gvd_pkg::div_t      div,
    output gvd_pkg::ctx_t      ctx
);
    import gvd_pkg::*;

    logic             valid_reg;
    div_t             div_reg;
    div_t             div_next;
    ctx_t             ctx_reg;
    logic [DenBits:0]   trial;
    logic [DenBits+1:0] diff;

    // One restoring division step: one quotient bit per cell.
    always_comb
    begin
        trial = {prev_div.rem[DenBits-1:0], prev_div.num[DivBits-1]};
        diff = {1'b0, trial} - {2'b00, prev_div.den};
        div_next = prev_div;
        div_next.num = {prev_div.num[DivBits-2:0], 1'b0};
        div_next.rem = diff[DenBits+1] ? trial : diff[DenBits:0];
        div_next.quo = {prev_div.quo[DivBits-2:0], ~diff[DenBits+1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg <= div_next;
            ctx_reg <= prev_ctx;
        end
    end

    assign valid = valid_reg;
    assign div = div_reg;
    assign ctx = ctx_reg;

endmodule
`default_nettype wire

@@ sv/gvd_div_chain.sv @@
`default_nettype none
module gvd_div_chain (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          head_valid,
    input  wire gvd_pkg::div_t head_div,
    input  wire gvd_pkg::ctx_t head_ctx,
    output logic               tail_valid,
    output gvd_pkg::div_t      tail_div,
    output gvd_pkg::ctx_t      tail_ctx
);
    import gvd_pkg::*;

    logic valid_tap [DivBits+1];
    div_t div_tap   [DivBits+1];
    ctx_t ctx_tap   [DivBits+1];

    assign valid_tap[0] = head_valid;
    assign div_tap[0] = head_div;
    assign ctx_tap[0] = head_ctx;

    for (genvar i = 0; i < DivBits; i++)
    begin : g_cell
        gvd_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .prev_valid (valid_tap[i]),
            .prev_div   (div_tap[i]),
            .prev_ctx   (ctx_tap[i]),
            .valid      (valid_tap[i+1]),
            .div        (div_tap[i+1]),
            .ctx        (ctx_tap[i+1])
        );
    end

    assign tail_valid = valid_tap[DivBits];
    assign tail_div = div_tap[DivBits];
    assign tail_ctx = ctx_tap[DivBits];

endmodule
`default_nettype wire

@@ sv/fat_volume_geometry_decode_unit.sv @@
// Takes one transaction per cycle unless a held response stalls the pipeline.
// Path: input register, 32-cell root division chain, middle register, 32-cell
// cluster division chain, response register; one quotient bit per cell.
// A held response stalls the whole pipeline, the request side included.
// Reset clears all valid bits; no transactions are in flight after reset.
`default_nettype none
module fat_volume_geometry_decode_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire gvd_pkg::geo_req_t req_data,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output gvd_pkg::geo_rsp_t     rsp_data
);
    import gvd_pkg::*;

    logic     adv;
    logic     s0_valid_reg;
    div_t     s0_div_reg;
    div_t     s0_div_next;
    ctx_t     s0_ctx_reg;
    ctx_t     s0_ctx_next;
    logic     c1_valid;
    div_t     c1_div;
    ctx_t     c1_ctx;
    logic     s1_valid_reg;
    div_t     s1_div_reg;
    div_t     s1_div_next;
    ctx_t     s1_ctx_reg;
    ctx_t     s1_ctx_next;
    logic     c2_valid;
    div_t     c2_div;
    ctx_t     c2_ctx;
    logic     rsp_valid_reg;
    geo_rsp_t rsp_reg;
    geo_rsp_t rsp_next;
    logic [20:0] root_bytes;
    logic [24:0] meta;
    logic [31:0] clusters;

    assign adv = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;

    always_comb
    begin
        root_bytes = {req_data.root_entry_count, {EntryBytesLog{1'b0}}};
        s0_ctx_next = '0;
        s0_ctx_next.unknown = (req_data.bytes_per_sector == '0);
        s0_ctx_next.spc = req_data.sectors_per_cluster;
        s0_ctx_next.root_start = {8'd0, req_data.reserved_sectors}
            + 24'(req_data.table_copies) * 24'(req_data.sectors_per_table);
        s0_ctx_next.cbytes = 24'(req_data.sectors_per_cluster)
            * 24'(req_data.bytes_per_sector);
        s0_ctx_next.total = (req_data.total_sectors_long > {16'd0, req_data.total_sectors_short})
            ? req_data.total_sectors_long : {16'd0, req_data.total_sectors_short};
        s0_div_next.num = {11'd0, root_bytes};
        s0_div_next.den = req_data.bytes_per_sector;
        s0_div_next.rem = '0;
        s0_div_next.quo = '0;
    end

    always_comb
    begin
        s1_ctx_next = c1_ctx;
        s1_ctx_next.rds = c1_div.quo[21:0] + {21'd0, (c1_div.rem != '0)};
        s1_ctx_next.data_start = {1'b0, c1_ctx.root_start} + {4'd0, c1_div.quo[20:0]};
        meta = {1'b0, c1_ctx.root_start} + {3'd0, s1_ctx_next.rds};
        s1_ctx_next.err = ({7'd0, meta} > c1_ctx.total) || (c1_ctx.spc == '0);
        s1_ctx_next.data = s1_ctx_next.err ? '0 : (c1_ctx.total - {7'd0, meta});
        s1_div_next.num = s1_ctx_next.data;
        s1_div_next.den = {8'd0, c1_ctx.spc};
        s1_div_next.rem = '0;
        s1_div_next.quo = '0;
    end

    always_comb
    begin
        clusters = c2_ctx.err ? '0 : c2_div.quo;
        rsp_next = '0;
        if (c2_ctx.unknown)
        begin
            rsp_next.fs_kind = KIND_UNKNOWN;
        end
        else
        begin
            if (clusters < Fat12Limit)
            begin
                rsp_next.fs_kind = KIND_FAT12;
            end
            else if (clusters < Fat16Limit)
            begin
                rsp_next.fs_kind = KIND_FAT16;
            end
            else
            begin
                rsp_next.fs_kind = KIND_FAT32;
            end
            rsp_next.root_dir_sectors = c2_ctx.rds;
            rsp_next.data_sector_count = c2_ctx.data;
            rsp_next.cluster_total = clusters;
            rsp_next.root_start_sector = c2_ctx.root_start;
            rsp_next.data_start_sector = c2_ctx.data_start;
            rsp_next.cluster_bytes = c2_ctx.cbytes;
            rsp_next.geometry_error = c2_ctx.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= req_valid;
            s1_valid_reg <= c1_valid;
            rsp_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_div_reg <= s0_div_next;
            s0_ctx_reg <= s0_ctx_next;
            s1_div_reg <= s1_div_next;
            s1_ctx_reg <= s1_ctx_next;
            rsp_reg <= rsp_next;
        end
    end

    gvd_div_chain u_root_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .head_valid (s0_valid_reg),
        .head_div   (s0_div_reg),
        .head_ctx   (s0_ctx_reg),
        .tail_valid (c1_valid),
        .tail_div   (c1_div),
        .tail_ctx   (c1_ctx)
    );

    gvd_div_chain u_cluster_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .head_valid (s1_valid_reg),
        .head_div   (s1_div_reg),
        .head_ctx   (s1_ctx_reg),
        .tail_valid (c2_valid),
        .tail_div   (c2_div),
        .tail_ctx   (c2_ctx)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data = rsp_reg;

endmodule
`default_nettype wire

@@ sv/gvd_checker.sv @@
`default_nettype none
module gvd_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire gvd_pkg::geo_req_t req_data,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire gvd_pkg::geo_rsp_t rsp_data
);
    import gvd_pkg::*;

    a_req_known: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |-> !$isunknown(req_data))
        else $error("Request carries unknown bits.");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("Stalled response changed.");

    a_req_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("Request stalled without a held response.");

    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.fs_kind == KIND_UNKNOWN |->
        !rsp_data.geometry_error && rsp_data.root_dir_sectors == '0)
        else $error("Unknown volume carries layout fields.");

    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.geometry_error |->
        rsp_data.data_sector_count == '0 && rsp_data.cluster_total == '0
        && rsp_data.fs_kind == KIND_FAT12)
        else $error("Flagged geometry has nonzero counts.");

endmodule

bind fat_volume_geometry_decode_unit gvd_checker u_gvd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
`default_nettype wire
